### design/rfpc_pkg.sv
// Shared definitions for the ring FIFO with peek and checksum.
// Holds parameter defaults, field widths, operation and status codes and the FSM type.
// No dependencies.
package rfpc_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 8;

    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 8;
    localparam int POS_W   = 4;
    localparam int AMT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = 16;
    localparam int FILL_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CSUM  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM
    } t_state;

endpackage

### design/rfpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters. Depends on rfpc_pkg for its defaults.
module rfpc_ram
    import rfpc_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/ring_fifo_peek_checksum.sv
// Top level of the ring FIFO with push, pop, peek, checksum and clear operations.
// Depends on rfpc_pkg and instantiates rfpc_ram for the element store.
//
// Usage: an operation word (i_func, i_push_data, i_position, i_amount) is taken at a
// rising edge where start is high and busy is low. Exactly one result word follows
// on o_read_data, o_status, o_sum and o_fill_level, valid for the single cycle in
// which o_done is high. The receiver cannot stall; it must take the word then.
//
// Throughput: push, clear, unused codes and every error case finish without leaving
// ST_IDLE; the result shows in the cycle after the accept and busy stays low, so a
// new word may be issued every cycle. Pop and a valid peek pass through ST_READ,
// since the element RAM has a registered read port, and their result is registered
// after it. A valid checksum walks its N elements in ST_SUM, since the single RAM
// read port delivers one element per cycle into the running sum. While busy is high,
// start is ignored.
// Reset (synchronous, active low) empties the FIFO by clearing the pointers and the
// fill count. The element RAM is not cleared and needs no clearing pass, because
// only entries that were written can ever be read.
module ring_fifo_peek_checksum
    import rfpc_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic [POS_W-1:0]  i_position,
    input  logic [AMT_W-1:0]  i_amount,
    output logic              o_done,
    output logic [DATA_W-1:0] o_read_data,
    output logic [STAT_W-1:0] o_status,
    output logic [SUM_W-1:0]  o_sum,
    output logic [FILL_W-1:0] o_fill_level
);

    // Pointer width, fill count width, and a compare width that holds both the
    // fill count and the sum of position and amount.
    localparam int PW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > 6) ? OW : 6;

    localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
    localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

    // Adds an offset to a pointer modulo DEPTH. Callers guarantee the raw sum stays
    // below twice the depth, so one conditional subtract is enough.
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [PW:0] offset);
        logic [PW:0] s;
        s = {1'b0, base} + offset;
        if (s >= DEPTH_P) begin
            s = s - DEPTH_P;
        end
        return s[PW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [OW-1:0]  r_occ, n_occ;

    // Checksum walk: next address to read, reads still owed, running sum.
    logic [PW-1:0]    r_addr, n_addr;
    logic [AMT_W-1:0] r_left, n_left;
    logic [SUM_W-1:0] r_acc, n_acc;

    logic              r_done, n_done;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic [STAT_W-1:0] r_status, n_status;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic                 ram_we;
    logic [PW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [PW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [63:0]          rdata_ext;

    logic          accept;
    logic [CW-1:0] pos_c, amt_c, occ_c, clr_c;
    logic          peek_ok, csum_ok;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign pos_c   = CW'(i_position);
    assign amt_c   = CW'(i_amount);
    assign occ_c   = CW'(r_occ);
    assign clr_c   = (amt_c > occ_c) ? occ_c : amt_c;
    assign peek_ok = (pos_c < occ_c);
    assign csum_ok = ((pos_c + amt_c) <= occ_c);

    assign rdata_ext = 64'(ram_rdata);

    rfpc_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(WORD_BITS'(i_push_data)),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_POP: begin
                            if (r_occ != '0) begin
                                n_state = ST_READ;
                            end
                        end
                        FUNC_PEEK: begin
                            if (peek_ok) begin
                                n_state = ST_READ;
                            end
                        end
                        FUNC_CSUM: begin
                            if (csum_ok && (i_amount != '0)) begin
                                n_state = ST_SUM;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SUM: begin
                if (r_left == AMT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result word.
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_occ       = r_occ;
        n_addr      = r_addr;
        n_left      = r_left;
        n_acc       = r_acc;
        n_done      = 1'b0;
        n_read_data = r_read_data;
        n_status    = r_status;
        n_sum       = r_sum;
        n_fill      = r_fill;
        ram_we      = 1'b0;
        ram_waddr   = r_wp;
        ram_re      = 1'b0;
        ram_raddr   = r_rp;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Results that need no RAM data go out right away.
                    n_read_data = '0;
                    n_sum       = '0;
                    n_status    = STAT_OK;
                    case (i_func)
                        FUNC_PUSH: begin
                            if (r_occ == DEPTH_O) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                ram_we = 1'b1;
                                n_wp   = wrap_add(r_wp, (PW + 1)'(1));
                                n_occ  = r_occ + OW'(1);
                            end
                            n_done = 1'b1;
                        end
                        FUNC_POP: begin
                            if (r_occ == '0) begin
                                n_status = STAT_UNDERFLOW;
                                n_done   = 1'b1;
                            end else begin
                                ram_re = 1'b1;
                                n_rp   = wrap_add(r_rp, (PW + 1)'(1));
                                n_occ  = r_occ - OW'(1);
                            end
                        end
                        FUNC_PEEK: begin
                            if (peek_ok) begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_add(r_rp, (PW + 1)'(i_position));
                            end else begin
                                n_status = STAT_UNDERFLOW;
                                n_done   = 1'b1;
                            end
                        end
                        FUNC_CSUM: begin
                            if (!csum_ok) begin
                                n_status = STAT_UNDERFLOW;
                                n_done   = 1'b1;
                            end else if (i_amount == '0) begin
                                n_done = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_add(r_rp, (PW + 1)'(i_position));
                                n_addr    = wrap_add(r_rp, (PW + 1)'(i_position) +
                                                           (PW + 1)'(1));
                                n_left    = i_amount;
                                n_acc     = '0;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_rp   = wrap_add(r_rp, (PW + 1)'(clr_c));
                            n_occ  = r_occ - OW'(clr_c);
                            n_done = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                    n_fill = FILL_W'(n_occ);
                end
            end
            ST_READ: begin
                n_done      = 1'b1;
                n_read_data = rdata_ext[DATA_W-1:0];
                n_status    = STAT_OK;
                n_sum       = '0;
                n_fill      = FILL_W'(r_occ);
            end
            ST_SUM: begin
                // The word read last cycle is folded in; the next read overlaps it.
                n_acc = r_acc + rdata_ext[SUM_W-1:0];
                if (r_left == AMT_W'(1)) begin
                    n_done      = 1'b1;
                    n_read_data = '0;
                    n_status    = STAT_OK;
                    n_sum       = n_acc;
                    n_fill      = FILL_W'(r_occ);
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_addr    = wrap_add(r_addr, (PW + 1)'(1));
                    n_left    = r_left - AMT_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_occ   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_occ   <= n_occ;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_left      <= n_left;
        r_acc       <= n_acc;
        r_read_data <= n_read_data;
        r_status    <= n_status;
        r_sum       <= n_sum;
        r_fill      <= n_fill;
    end

    assign o_done       = r_done;
    assign o_read_data  = r_read_data;
    assign o_status     = r_status;
    assign o_sum        = r_sum;
    assign o_fill_level = r_fill;

endmodule

### test/tb_ring_fifo_peek_checksum.sv
// Self-checking testbench for ring_fifo_peek_checksum: a directed table, then random words.
// Every accepted word is run through a local FIFO predictor and the single result is compared.
// Depends on rfpc_pkg and the ring_fifo_peek_checksum RTL.
module tb_ring_fifo_peek_checksum;
    timeunit 1ns;
    timeprecision 1ps;

    import rfpc_pkg::*;

    // The three operation codes the block does not use. They must leave the FIFO untouched.
    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    localparam int PTR_W          = $clog2(DEPTH_DEF);
    localparam int RANDOM_WORDS   = 850;
    localparam int IDLE_PCT       = 15;
    // Random words in this window are driven back to back with no idle cycles.
    localparam int NO_IDLE_FIRST  = 300;
    localparam int NO_IDLE_LAST   = 450;
    // The longest operation is a full checksum over DEPTH elements.
    localparam int TAIL_CYCLES    = 4 * (DEPTH_DEF + 2);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [AMT_W-1:0]  amt;
    } fifo_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] fill;
    } fifo_result_t;

    // One word of the directed part. When has_exp is set, the result was typed in by hand
    // and is compared instead of the prediction; the predictor still tracks the state.
    typedef struct packed {
        fifo_word_t   word;
        logic         has_exp;
        fifo_result_t exp;
    } directed_word_t;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [DATA_W-1:0] i_push_data = '0;
    logic [POS_W-1:0]  i_position  = '0;
    logic [AMT_W-1:0]  i_amount    = '0;
    logic              o_done;
    logic [DATA_W-1:0] o_read_data;
    logic [STAT_W-1:0] o_status;
    logic [SUM_W-1:0]  o_sum;
    logic [FILL_W-1:0] o_fill_level;

    // Predictor state: a copy of the element store, both pointers and the fill count.
    logic [DATA_W-1:0] fifo_mem [DEPTH_DEF];
    logic [PTR_W-1:0]  wr_ptr = '0;
    logic [PTR_W-1:0]  rd_ptr = '0;
    logic [FILL_W-1:0] held   = '0;

    directed_word_t directed_q [$];
    fifo_result_t   expected_q [$];
    int             mismatch_cnt = 0;
    int             quiet_cycles = 0;

    ring_fifo_peek_checksum #(
        .DEPTH     (DEPTH_DEF),
        .WORD_BITS (WORD_BITS_DEF)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_push_data  (i_push_data),
        .i_position   (i_position),
        .i_amount     (i_amount),
        .o_done       (o_done),
        .o_read_data  (o_read_data),
        .o_status     (o_status),
        .o_sum        (o_sum),
        .o_fill_level (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation word to the predictor state and returns the result it causes.
    // Pointers are PTR_W bits wide, so they wrap modulo DEPTH on their own.
    function automatic fifo_result_t fifo_apply(fifo_word_t w);
        fifo_result_t     r;
        logic [PTR_W-1:0] slot;
        int               take;
        r = '0;
        case (w.func)
            FUNC_PUSH: begin
                if (held >= DEPTH_DEF) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    fifo_mem[wr_ptr] = w.data;
                    wr_ptr = wr_ptr + 1'b1;
                    held = held + 1'b1;
                end
            end
            FUNC_POP: begin
                if (held == 0) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    r.read_data = fifo_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    held = held - 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (w.pos >= held) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    slot = rd_ptr + w.pos;
                    r.read_data = fifo_mem[slot];
                end
            end
            FUNC_CSUM: begin
                if (int'(w.pos) + int'(w.amt) > int'(held)) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    for (int i = 0; i < int'(w.amt); i++) begin
                        slot = PTR_W'((int'(rd_ptr) + int'(w.pos) + i) % DEPTH_DEF);
                        r.sum = r.sum + SUM_W'(fifo_mem[slot]);
                    end
                end
            end
            FUNC_CLEAR: begin
                // Clearing more than is held only drops what is there; never an error.
                take = (w.amt > held) ? int'(held) : int'(w.amt);
                rd_ptr = PTR_W'((int'(rd_ptr) + take) % DEPTH_DEF);
                held = held - FILL_W'(take);
            end
            default: begin
            end
        endcase
        r.fill = held;
        return r;
    endfunction

    // Appends one directed row, repeated reps times. Repeated pushes count the data up
    // so that every stored element is different.
    function automatic void add_row(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] data,
                                    logic [POS_W-1:0] pos, logic [AMT_W-1:0] amt,
                                    int reps, logic has_exp, logic [DATA_W-1:0] rd,
                                    logic [STAT_W-1:0] st, logic [SUM_W-1:0] sum,
                                    logic [FILL_W-1:0] fill);
        directed_word_t d;
        for (int k = 0; k < reps; k++) begin
            d.word.func = func;
            d.word.data = data + DATA_W'(k);
            d.word.pos  = pos;
            d.word.amt  = amt;
            d.has_exp   = has_exp;
            d.exp.read_data = rd;
            d.exp.status    = st;
            d.exp.sum       = sum;
            d.exp.fill      = fill;
            directed_q.push_back(d);
        end
    endfunction

    // Stimulus and prediction. At each rising edge the word on the ports is checked for
    // acceptance (start high, busy low) against the values from before the edge. An accepted
    // word goes through the predictor first, so that the next random word is shaped by the
    // fill level that word leaves behind.
    initial begin
        directed_word_t d;
        fifo_word_t     cur_word;
        logic           cur_has_exp;
        fifo_result_t   cur_exp;
        fifo_result_t   predicted;
        logic           accepted;
        logic           idle_ok;
        int             directed_cnt;
        int             total_words;
        int             sent_cnt;
        int             taken_cnt;
        int             pick;
        int             trend_left;
        logic           trend_fill;
        int             pos_max;

        cur_word    = '0;
        cur_has_exp = 1'b0;
        cur_exp     = '0;
        sent_cnt    = 0;
        taken_cnt   = 0;
        trend_left  = 0;
        trend_fill  = 1'b1;

        // Directed part. Empty FIFO first: every read reports underflow, a zero-length
        // checksum over an empty window is fine, and clearing an empty FIFO is not an error.
        add_row(FUNC_POP,   8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_UNDERFLOW, 16'h0, 5'd0);
        add_row(FUNC_PEEK,  8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_UNDERFLOW, 16'h0, 5'd0);
        add_row(FUNC_CSUM,  8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_CSUM,  8'h00, 4'd0,  5'd1,  1, 1'b1, 8'h00, STAT_UNDERFLOW, 16'h0, 5'd0);
        add_row(FUNC_CLEAR, 8'h00, 4'd0,  5'd16, 1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd0);
        // Fill to the top with both data extremes among the elements.
        add_row(FUNC_PUSH,  8'hFF, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd1);
        add_row(FUNC_PUSH,  8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd2);
        add_row(FUNC_PUSH,  8'h5A, 4'd0,  5'd0,  14, 1'b0, 8'h00, STAT_OK,       16'h0, 5'd0);
        // Full: a push is refused, the last slot can be peeked, the whole FIFO summed,
        // and a window that runs one past the end is refused.
        add_row(FUNC_PUSH,  8'h77, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OVERFLOW,  16'h0, 5'd16);
        add_row(FUNC_PEEK,  8'h00, 4'd15, 5'd0,  1, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_CSUM,  8'h00, 4'd0,  5'd16, 1, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_CSUM,  8'h00, 4'd1,  5'd16, 1, 1'b1, 8'h00, STAT_UNDERFLOW, 16'h0, 5'd16);
        add_row(FUNC_CSUM,  8'h00, 4'd15, 5'd1,  1, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        // Unused codes change nothing and return zeros.
        add_row(FUNC_RSVD5, 8'hFF, 4'd15, 5'd16, 1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd16);
        add_row(FUNC_RSVD6, 8'hFF, 4'd15, 5'd16, 1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd16);
        add_row(FUNC_RSVD7, 8'hFF, 4'd15, 5'd16, 1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd16);
        // The oldest element is the first push. Clear by zero and by a few.
        add_row(FUNC_POP,   8'h00, 4'd0,  5'd0,  1, 1'b1, 8'hFF, STAT_OK,        16'h0, 5'd15);
        add_row(FUNC_CLEAR, 8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd15);
        add_row(FUNC_CLEAR, 8'h00, 4'd0,  5'd3,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd12);
        // Refill to full, so the held elements run across the wrap point, then read across it.
        add_row(FUNC_PUSH,  8'h80, 4'd0,  5'd0,  4, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_CSUM,  8'h00, 4'd0,  5'd16, 1, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_PEEK,  8'h00, 4'd0,  5'd0,  1, 1'b0, 8'h00, STAT_OK,        16'h0, 5'd0);
        add_row(FUNC_CLEAR, 8'h00, 4'd0,  5'd16, 1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd0);
        // One element in and out again with the pointers away from zero.
        add_row(FUNC_PUSH,  8'h3C, 4'd0,  5'd0,  1, 1'b1, 8'h00, STAT_OK,        16'h0, 5'd1);
        add_row(FUNC_POP,   8'h00, 4'd0,  5'd0,  1, 1'b1, 8'h3C, STAT_OK,        16'h0, 5'd0);

        directed_cnt = directed_q.size();
        total_words  = directed_cnt + RANDOM_WORDS;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_cnt < total_words) begin
            @(posedge i_clk);
            accepted = (start === 1'b1) && (busy === 1'b0);
            if (accepted) begin
                predicted = fifo_apply(cur_word);
                expected_q.push_back(cur_has_exp ? cur_exp : predicted);
                taken_cnt++;
            end
            // A word that is still waiting for busy to drop stays on the ports untouched.
            if (accepted || !start) begin
                idle_ok = !(sent_cnt >= directed_cnt + NO_IDLE_FIRST &&
                            sent_cnt <  directed_cnt + NO_IDLE_LAST);
                if (sent_cnt == total_words) begin
                    start <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 99) < IDLE_PCT) begin
                    start <= 1'b0;
                end else begin
                    if (directed_q.size() != 0) begin
                        d           = directed_q.pop_front();
                        cur_word    = d.word;
                        cur_has_exp = d.has_exp;
                        cur_exp     = d.exp;
                    end else begin
                        // The random part swings between filling and draining phases so
                        // that both the full and the empty corners are reached often.
                        if (trend_left == 0) begin
                            trend_fill = ~trend_fill;
                            trend_left = $urandom_range(20, 60);
                        end
                        trend_left--;
                        cur_has_exp   = 1'b0;
                        cur_word.data = DATA_W'($urandom);
                        cur_word.pos  = POS_W'($urandom);
                        cur_word.amt  = AMT_W'($urandom_range(0, 16));
                        pick = $urandom_range(0, 99);
                        if (pick < 5) begin
                            cur_word.func = FUNC_W'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
                        end else if (pick < (trend_fill ? 50 : 25)) begin
                            cur_word.func = FUNC_PUSH;
                        end else if (pick < (trend_fill ? 62 : 55)) begin
                            cur_word.func = FUNC_POP;
                        end else if (pick < (trend_fill ? 77 : 70)) begin
                            cur_word.func = FUNC_PEEK;
                            // Mostly a slot that is held; the rest use any position and may read out of range.
                            if (held != 0 && $urandom_range(0, 99) < 80)
                                cur_word.pos = POS_W'($urandom_range(0, held - 1));
                        end else if (pick < (trend_fill ? 92 : 85)) begin
                            cur_word.func = FUNC_CSUM;
                            // Mostly a window that fits; the rest may run past the end.
                            if ($urandom_range(0, 99) < 80) begin
                                pos_max = (held > 15) ? 15 : int'(held);
                                cur_word.pos = POS_W'($urandom_range(0, pos_max));
                                cur_word.amt = AMT_W'($urandom_range(0,
                                                      int'(held) - int'(cur_word.pos)));
                            end
                        end else begin
                            cur_word.func = FUNC_CLEAR;
                            if ($urandom_range(0, 99) < 70)
                                cur_word.amt = AMT_W'($urandom_range(0, 3));
                        end
                    end
                    i_func      <= cur_word.func;
                    i_push_data <= cur_word.data;
                    i_position  <= cur_word.pos;
                    i_amount    <= cur_word.amt;
                    start       <= 1'b1;
                    sent_cnt++;
                end
            end
        end

        // Everything is accepted. Wait for the last results, then a little longer so a
        // stray extra strobe would still be caught.
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result checker. The block cannot be stalled, so every strobe is one result word that
    // must match the oldest expectation in every field.
    always @(posedge i_clk) begin : check_results
        fifo_result_t want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: result word with none expected: rd=%02h st=%0d sum=%04h fill=%0d",
                             $time, o_read_data, o_status, o_sum, o_fill_level);
            end else begin
                want = expected_q.pop_front();
                if (o_read_data !== want.read_data || o_status !== want.status ||
                    o_sum !== want.sum || o_fill_level !== want.fill) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: expected rd=%02h st=%0d sum=%04h fill=%0d, got rd=%02h st=%0d sum=%04h fill=%0d",
                                 $time, want.read_data, want.status, want.sum, want.fill,
                                 o_read_data, o_status, o_sum, o_fill_level);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with neither a word taken nor a result given.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
